FILE: src/kf2d_pkg.sv
// ---------------------------------------------------------------------------
// kf2d_pkg - shared types and constants for the 2D tracker
// Opcodes, Q16 constants, step selects, command and status structs, saturation.
// ---------------------------------------------------------------------------
`default_nettype none
package kf2d_pkg;

  localparam int unsigned OpW = 3;
  localparam logic [OpW-1:0] OP_RESET   = 3'd0;
  localparam logic [OpW-1:0] OP_INIT    = 3'd1;
  localparam logic [OpW-1:0] OP_PREDICT = 3'd2;
  localparam logic [OpW-1:0] OP_PONLY   = 3'd3;
  localparam logic [OpW-1:0] OP_UPDATE  = 3'd4;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [31:0] QUARTER_Q16 = 32'sd16384;
  localparam logic [31:0]        TICK_Q16    = 32'd3277;

  // multiplier operand selects
  typedef enum logic [3:0] {
    M_VXDT, M_VYDT, M_QDT, M_PVXVXDT, M_PVYVYDT, M_PXVXDT, M_QVDT, M_PYVYDT,
    M_KX, M_KY, M_KVX, M_KVY, M_CXX, M_CYY, M_CVXX, M_CVYY
  } mstep_t;

  // divider jobs
  typedef enum logic [1:0] { D_KX, D_KY, D_KVX, D_KVY } dsel_t;

  typedef struct packed {
    logic   load;      // latch input item
    logic   do_reset;
    logic   do_init;
    logic   mul_go;    // run multiply-accumulate step mstep
    mstep_t mstep;
    logic   div_go;
    dsel_t  dsel;
    logic   copy_pred; // estimate <= prediction
    logic   add_dt;
    logic   add_tick;
    logic   qv_go;     // compute qv = (q+5)/10
  } kf2d_cmd_t;

  typedef struct packed {
    logic           busy;    // mul or div unit running
    logic           init_flag;
    logic [OpW-1:0] op;
    logic           dt_zero;
  } kf2d_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/kf2d_div.sv
// ---------------------------------------------------------------------------
// kf2d_div - restoring divider for gain terms
// Signed (n<<16)/d, truncated, saturated; zero divisor gives 0.
// ---------------------------------------------------------------------------
`default_nettype none
module kf2d_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] num,
  input  wire logic signed [32:0] den,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import kf2d_pkg::*;

  logic [48:0] rem_q;  // quotient bits shift in
  logic [32:0] dmag;
  logic [33:0] part;
  logic [5:0]  cnt;
  logic        neg;
  logic        dz;
  logic [33:0] trial;
  logic [48:0] q;

  assign trial = {part[32:0], rem_q[48]} - {1'b0, dmag};
  assign q = rem_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd49;
        neg   <= num[32] ^ den[32];
        dz    <= (den == '0);
        dmag  <= den[32] ? 33'(-den) : 33'(den);
        rem_q <= {(num[32] ? 33'(-num) : 33'(num)), 16'd0};
        part  <= '0;
      end else if (busy) begin
        if (trial[33]) begin
          part  <= {part[32:0], rem_q[48]};
          rem_q <= {rem_q[47:0], 1'b0};
        end else begin
          part  <= trial;
          rem_q <= {rem_q[47:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dz) quo = '0;
    else if (neg) quo = (q > 49'd2147483648) ? 32'sh80000000 : 32'(-q);
    else quo = (q > 49'd2147483647) ? 32'sh7fffffff : q[31:0];
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy);
  assert property (@(posedge clk) disable iff (rst) done |-> !busy);
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy));
endmodule
`default_nettype wire

FILE: src/kf2d_datapath.sv
// ---------------------------------------------------------------------------
// kf2d_datapath - tracker state and arithmetic
// One registered multiplier, shared divider, accumulate and clamp logic.
// ---------------------------------------------------------------------------
`default_nettype none
module kf2d_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire kf2d_pkg::kf2d_cmd_t    cmd,
  output kf2d_pkg::kf2d_sts_t         sts,
  input  wire logic [2:0]             in_op,
  input  wire logic [23:0]            in_dt,
  input  wire logic signed [31:0]     in_mx,
  input  wire logic signed [31:0]     in_my,
  input  wire logic [30:0]            q_reg,
  input  wire logic [30:0]            r_reg,
  input  wire logic [30:0]            vmax_reg,
  output logic signed [31:0]          est_x,
  output logic signed [31:0]          est_y,
  output logic signed [31:0]          est_vx,
  output logic signed [31:0]          est_vy,
  output logic                        init_flag,
  output logic [31:0]                 time_sum
);
  import kf2d_pkg::*;

  typedef enum logic [2:0] {PXX, PYY, PVXVX, PVYVY, PXVX, PYVY, PVXX, PVYY} cidx_t;

  logic [2:0]         op;
  logic [23:0]        dt;
  logic signed [31:0] mx, my;
  logic signed [31:0] est  [4];
  logic signed [31:0] pred [4];
  logic signed [31:0] cov  [8];
  logic signed [31:0] kx, ky, kvx, kvy, inn_x, inn_y;
  logic [30:0]        qv;

  // covariance reset pattern: unit position terms, quarter velocity terms
  function automatic logic signed [31:0] cov_rst(input int i);
    if (i == int'(PXX) || i == int'(PYY)) return ONE_Q16;
    if (i == int'(PVXVX) || i == int'(PVYVY)) return QUARTER_Q16;
    return '0;
  endfunction

  // multiplier: stage 1 selects and registers product, stage 2 accumulates
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic               mvalid;
  mstep_t             mstep_d;
  logic signed [31:0] mr;

  always_comb begin
    ma = '0;
    mb = 33'(dt);
    unique case (cmd.mstep)
      M_VXDT:    ma = 33'(est[2]);
      M_VYDT:    ma = 33'(est[3]);
      M_QDT:     ma = {2'b0, q_reg};
      M_PVXVXDT: ma = 33'(cov[PVXVX]);
      M_PVYVYDT: ma = 33'(cov[PVYVY]);
      M_PXVXDT:  ma = 33'(cov[PXVX]);
      M_QVDT:    ma = {2'b0, qv};
      M_PYVYDT:  ma = 33'(cov[PYVY]);
      M_KX:      begin ma = 33'(kx);  mb = 33'(inn_x); end
      M_KY:      begin ma = 33'(ky);  mb = 33'(inn_y); end
      M_KVX:     begin ma = 33'(kvx); mb = 33'(inn_x); end
      M_KVY:     begin ma = 33'(kvy); mb = 33'(inn_y); end
      M_CXX:     begin ma = 33'(ONE_Q16) - 33'(kx); mb = 33'(cov[PXX]);  end
      M_CYY:     begin ma = 33'(ONE_Q16) - 33'(ky); mb = 33'(cov[PYY]);  end
      M_CVXX:    begin ma = 33'(ONE_Q16) - 33'(kx); mb = 33'(cov[PVXX]); end
      M_CVYY:    begin ma = 33'(ONE_Q16) - 33'(ky); mb = 33'(cov[PVYY]); end
      default:   ma = '0;
    endcase
  end

  // rounded product, arithmetic shift floors
  assign mr = sat32((prod + 66'sd32768) >>> 16);

  function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
                                                input logic [30:0] m);
    logic signed [32:0] mm;
    mm = {2'b0, m};
    if (33'(v) > mm) return {1'b0, m};
    if (33'(v) < -mm) return 32'(-mm);
    return v;
  endfunction

  // divider
  logic               d_start, d_busy, d_done;
  logic signed [32:0] d_num, d_den;
  logic signed [31:0] d_quo;
  dsel_t              dsel_q;
  logic signed [32:0] s0, s1;

  assign s0 = 33'(cov[PXX]) + {2'b0, r_reg};
  assign s1 = 33'(cov[PYY]) + {2'b0, r_reg};
  assign d_start = cmd.div_go;
  always_comb begin
    unique case (cmd.dsel)
      D_KX:    begin d_num = 33'(cov[PXX]);  d_den = s0; end
      D_KY:    begin d_num = 33'(cov[PYY]);  d_den = s1; end
      D_KVX:   begin d_num = 33'(cov[PVXX]); d_den = s0; end
      default: begin d_num = 33'(cov[PVYY]); d_den = s1; end
    endcase
  end

  kf2d_div u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(d_num), .den(d_den),
    .busy(d_busy), .done(d_done), .quo(d_quo)
  );

  // qv = (q+5)/10 by reciprocal multiply, exact for any 32-bit numerator
  logic [31:0] qv_num;
  logic [63:0] qv_prod;
  assign qv_num  = {1'b0, q_reg} + 32'd5;
  assign qv_prod = {32'd0, qv_num} * {32'd0, 32'hcccccccd};

  logic [32:0] tsum;
  always_comb begin
    tsum = {1'b0, time_sum};
    if (cmd.add_dt) tsum = tsum + 33'(dt);
    else if (cmd.add_tick) tsum = tsum + 33'(TICK_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid <= 1'b0;
      init_flag <= 1'b0;
      time_sum <= '0;
      for (int i = 0; i < 4; i++) begin est[i] <= '0; pred[i] <= '0; end
      for (int i = 0; i < 8; i++) cov[i] <= cov_rst(i);
    end else begin
      if (cmd.load) begin
        op <= in_op; dt <= in_dt; mx <= in_mx; my <= in_my;
      end
      if (cmd.do_reset || cmd.do_init) begin
        for (int i = 0; i < 8; i++) cov[i] <= cov_rst(i);
      end
      if (cmd.do_reset) begin
        for (int i = 0; i < 4; i++) begin est[i] <= '0; pred[i] <= '0; end
        init_flag <= 1'b0;
        time_sum <= '0;
      end
      if (cmd.do_init) begin
        est[0] <= mx; est[1] <= my; est[2] <= '0; est[3] <= '0;
        pred[0] <= mx; pred[1] <= my; pred[2] <= '0; pred[3] <= '0;
        init_flag <= 1'b1;
      end
      if (cmd.copy_pred) for (int i = 0; i < 4; i++) est[i] <= pred[i];
      if (cmd.add_dt || cmd.add_tick) time_sum <= tsum[32] ? '1 : tsum[31:0];

      // innovations are ready from load onward
      inn_x <= sat32(66'(mx) - 66'(pred[0]));
      inn_y <= sat32(66'(my) - 66'(pred[1]));

      mvalid <= cmd.mul_go;
      if (cmd.mul_go) begin
        prod <= 66'(ma) * 66'(mb);
        mstep_d <= cmd.mstep;
      end
      if (mvalid) begin
        unique case (mstep_d)
          M_VXDT: begin
            pred[0] <= sat32(66'(est[0]) + 66'(mr));
            pred[2] <= est[2]; pred[3] <= est[3];
          end
          M_VYDT:    pred[1] <= sat32(66'(est[1]) + 66'(mr));
          M_QDT: begin
            // q*dt accumulates into Pxx and Pyy
            cov[PXX] <= sat32(66'(cov[PXX]) + 66'(mr));
            cov[PYY] <= sat32(66'(cov[PYY]) + 66'(mr));
          end
          M_PVXVXDT: cov[PXVX] <= sat32(66'(cov[PXVX]) + 66'(mr));
          M_PVYVYDT: cov[PYVY] <= sat32(66'(cov[PYVY]) + 66'(mr));
          M_PXVXDT:  cov[PVXX] <= sat32(66'(cov[PVXX]) + 66'(mr));
          M_QVDT: begin
            cov[PVXVX] <= sat32(66'(cov[PVXVX]) + 66'(mr));
            cov[PVYVY] <= sat32(66'(cov[PVYVY]) + 66'(mr));
          end
          M_PYVYDT:  cov[PVYY] <= sat32(66'(cov[PVYY]) + 66'(mr));
          M_KX:  est[0] <= sat32(66'(pred[0]) + 66'(mr));
          M_KY:  est[1] <= sat32(66'(pred[1]) + 66'(mr));
          M_KVX: est[2] <= clampv(sat32(66'(pred[2]) + 66'(mr)), vmax_reg);
          M_KVY: est[3] <= clampv(sat32(66'(pred[3]) + 66'(mr)), vmax_reg);
          M_CXX:  cov[PXX]  <= mr;
          M_CYY:  cov[PYY]  <= mr;
          M_CVXX: cov[PVXX] <= mr;
          M_CVYY: cov[PVYY] <= mr;
          default: ;
        endcase
      end

      if (cmd.div_go) dsel_q <= cmd.dsel;
      if (d_done) begin
        unique case (dsel_q)
          D_KX:    kx  <= d_quo;
          D_KY:    ky  <= d_quo;
          D_KVX:   kvx <= d_quo;
          default: kvy <= d_quo;
        endcase
      end

      if (cmd.qv_go) qv <= {2'b0, qv_prod[63:35]};
    end
  end

  assign sts.busy      = d_busy | mvalid;
  assign sts.init_flag = init_flag;
  assign sts.op        = op;
  assign sts.dt_zero   = (dt == '0);

  assign est_x  = est[0];
  assign est_y  = est[1];
  assign est_vx = est[2];
  assign est_vy = est[3];

  assert property (@(posedge clk) disable iff (rst) cmd.do_init |=> init_flag);
  assert property (@(posedge clk) disable iff (rst) cmd.do_reset |=> time_sum == '0);
  assert property (@(posedge clk) disable iff (rst) d_done |-> !cmd.div_go);
endmodule
`default_nettype wire

FILE: src/kf2d_ctrl.sv
// ---------------------------------------------------------------------------
// kf2d_ctrl - operation sequencer
// Walks each op through its multiply and divide steps.
// ---------------------------------------------------------------------------
`default_nettype none
module kf2d_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  output logic                     in_ready,
  output logic                     res_load,
  input  wire logic                res_free,
  output kf2d_pkg::kf2d_cmd_t      cmd,
  input  wire kf2d_pkg::kf2d_sts_t sts
);
  import kf2d_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_QV, S_PRED, S_PONLY, S_DIV, S_UPD, S_TICK, S_WAIT, S_DONE
  } state_t;

  state_t     state;
  logic [3:0] step;
  logic       issued;
  kf2d_cmd_t  c;

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && res_free;

  always_comb begin
    c = '0;
    c.load = in_fire;
    c.mstep = mstep_t'(step);
    c.dsel = dsel_t'(step[1:0]);
    unique case (state)
      S_DISPATCH: begin
        c.do_reset = (sts.op == OP_RESET);
        c.do_init  = (sts.op == OP_INIT) || (sts.op == OP_UPDATE && !sts.init_flag);
        c.qv_go    = (sts.op == OP_PREDICT || sts.op == OP_PONLY) && sts.init_flag
                     && !sts.dt_zero;
      end
      S_PRED:  c.mul_go = !issued && !sts.busy;
      S_DIV:   c.div_go = !issued && !sts.busy;
      S_UPD:   begin
        c.mul_go = !issued && !sts.busy;
        c.mstep  = mstep_t'(4'(M_KX) + step);
      end
      S_PONLY: begin c.copy_pred = 1'b1; c.add_dt = 1'b1; end
      S_TICK:  c.add_tick = 1'b1;
      default: ;
    endcase
  end
  assign cmd = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      issued <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_DISPATCH;
        S_DISPATCH: begin
          step <= '0; issued <= 1'b0;
          if ((sts.op == OP_PREDICT || sts.op == OP_PONLY) && sts.init_flag)
            state <= sts.dt_zero ? (sts.op == OP_PONLY ? S_PONLY : S_DONE) : S_QV;
          else if (sts.op == OP_UPDATE && sts.init_flag) state <= S_DIV;
          else state <= S_DONE;
        end
        S_QV: if (!sts.busy) state <= S_PRED;
        S_PRED: begin
          if (c.mul_go) issued <= 1'b1;
          else if (issued && !sts.busy) begin
            issued <= 1'b0;
            step <= step + 4'd1;
            if (step == 4'(M_PYVYDT)) begin
              step <= '0;
              state <= (sts.op == OP_PONLY) ? S_PONLY : S_DONE;
            end
          end
        end
        S_PONLY: state <= S_DONE;
        S_DIV: begin
          if (c.div_go) issued <= 1'b1;
          else if (issued && !sts.busy) begin
            issued <= 1'b0;
            step <= step + 4'd1;
            if (step == 4'd3) begin step <= '0; state <= S_UPD; end
          end
        end
        S_UPD: begin
          if (c.mul_go) issued <= 1'b1;
          else if (issued && !sts.busy) begin
            issued <= 1'b0;
            step <= step + 4'd1;
            if (step == 4'd7) begin step <= '0; state <= S_TICK; end
          end
        end
        S_TICK: state <= S_DONE;
        S_DONE: if (res_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE);
  assert property (@(posedge clk) disable iff (rst) res_load |=> state == S_IDLE);
  assert property (@(posedge clk) disable iff (rst) $countones({c.mul_go, c.div_go}) <= 1);
endmodule
`default_nettype wire

FILE: src/kalman_filter_2d_const_velocity.sv
// ---------------------------------------------------------------------------
// kalman_filter_2d_const_velocity - 2D constant-velocity tracker
// Diagonal-gain Kalman filter, Q15.16 fixed point, one result per op.
// ---------------------------------------------------------------------------
// channel   dir  tdata fields (low bit first)                 tuser
// s_axis    in   op[2:0] dt[26:3] meas_x[58:27] meas_y[90:59]  -
// m_axis    out  pos_x vel... see port comment                 -
// cfg       in   wr_en, wr_index (0 q, 1 r, 2 vmax), wr_data     -
//
// Per op: reset/init/no-op go straight to the result; predict loads
// qv = (q+5)/10 by reciprocal multiply, then runs eight
// multiply-accumulate steps; predict_only then copies the prediction; update
// runs four divisions on the shared divider, then eight multiply steps.
// Reset clears estimate, covariance, time sum and flags synchronously; no clearing pass.
// One item in flight; the next input transaction is taken in the cycle after the
// result moves into the output register, which holds under m_axis_tready low.
// ---------------------------------------------------------------------------
`default_nettype none
module kalman_filter_2d_const_velocity (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // op[2:0] dt[26:3] meas_x[58:27] meas_y[90:59]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x[31:0] pos_y[63:32] vel_x[95:64] vel_y[127:96] is_initialized[128]
  // elapsed[160:129]
  output logic [167:0]      m_axis_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_wr_index,
  input  wire logic [30:0]  cfg_wr_data
);
  import kf2d_pkg::*;

  localparam logic [1:0] REG_Q = 2'd0, REG_R = 2'd1, REG_VMAX = 2'd2;

  logic [30:0] q_reg, r_reg, vmax_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg <= 31'd655; r_reg <= 31'd6554; vmax_reg <= 31'd655360;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        REG_Q:    q_reg <= cfg_wr_data;
        REG_R:    r_reg <= cfg_wr_data;
        REG_VMAX: vmax_reg <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  kf2d_cmd_t cmd;
  kf2d_sts_t sts;
  logic in_fire, res_load, res_free;
  logic signed [31:0] ex, ey, evx, evy;
  logic init_flag;
  logic [31:0] tsum;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign res_free = !m_axis_tvalid || m_axis_tready;

  kf2d_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_ready(s_axis_tready),
    .res_load(res_load), .res_free(res_free), .cmd(cmd), .sts(sts)
  );

  kf2d_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_axis_tdata[2:0]), .in_dt(s_axis_tdata[26:3]),
    .in_mx(s_axis_tdata[58:27]), .in_my(s_axis_tdata[90:59]),
    .q_reg(q_reg), .r_reg(r_reg), .vmax_reg(vmax_reg),
    .est_x(ex), .est_y(ey), .est_vx(evx), .est_vy(evy),
    .init_flag(init_flag), .time_sum(tsum)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {7'd0, tsum, init_flag, evy, evx, ey, ex};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_load |=> m_axis_tvalid);
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid);
  assert property (@(posedge clk) disable iff (rst) in_fire |=> !s_axis_tready);
endmodule
`default_nettype wire
